[rtl/skf_pkg.sv]
package skf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VAR_W     = 20;
    localparam int DEN_W     = VAR_W + 1;
    localparam int GAIN_W    = 16;
    localparam int QUO_W     = GAIN_W + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VARIANCE = 2'd2;

    localparam logic [VAR_W-1:0] RST_PROCESS_NOISE  = 20'd328;
    localparam logic [VAR_W-1:0] RST_MEASURE_NOISE  = 20'd52429;
    localparam logic [VAR_W-1:0] RST_START_VARIANCE = 20'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MULE,
        S_MULP,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul_e;
        logic mul_p;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[rtl/scalar_kalman_filter_top.sv]
// channel   dir  valid        stall        payload
// input     in   i_in_valid   o_in_stall   i_sample    (s16)
// output    out  o_out_valid  i_out_stall  o_estimate  (s16)
// config    in   i_cfg_we     -            i_cfg_index, i_cfg_data (u20)
//
// After the accept edge a word passes divider setup, 17 steps of the restoring gain
// divider, the error multiply, the variance multiply and the update. A new word is
// taken in the cycle after the result is registered, so one word is in flight at a
// time. Synchronous active-low reset restores the register defaults and clears the
// started flag. A stalled result holds in the output register while the next word is
// accepted and processed; that word's update waits until the output register is free.
module scalar_kalman_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [skf_pkg::SAMPLE_W-1:0] o_estimate,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]           i_cfg_data
);
    import skf_pkg::*;

    t_cmd    cmd;
    t_status status;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    skf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_estimate  (o_estimate)
    );

endmodule

[rtl/skf_ctrl.sv]
module skf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  skf_pkg::t_status i_status,
    output skf_pkg::t_cmd   o_cmd,
    output logic            o_in_stall
);
    import skf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_MULE;
                end
            end
            S_MULE: begin
                o_cmd.mul_e = 1'b1;
                n_state     = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/skf_datapath.sv]
module skf_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  skf_pkg::t_cmd                        i_cmd,
    output skf_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]            i_cfg_data,
    input  logic signed [skf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic signed [skf_pkg::SAMPLE_W-1:0]  o_estimate
);
    import skf_pkg::*;

    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int PE_W    = DIFF_W + GAIN_W + 1;
    localparam int PP_W    = QUO_W + VAR_W;
    localparam int EST_X_W = PE_W - GAIN_W + 1;

    logic [VAR_W-1:0]           r_q;
    logic [VAR_W-1:0]           r_r;
    logic [VAR_W-1:0]           r_p0;
    logic                       r_started;
    logic signed [SAMPLE_W-1:0] r_est;
    logic [VAR_W-1:0]           r_var;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [DEN_W-1:0]           r_den;
    logic                       r_den_zero;
    logic [DEN_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic [GAIN_W-1:0]          r_k;
    logic signed [PE_W-1:0]     r_prod_e;
    logic [PP_W-1:0]            r_prod_p;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic [DEN_W:0]             rem_sh;
    logic                       rem_ge;
    logic [GAIN_W-1:0]          k_c;
    logic signed [DIFF_W-1:0]   diff_c;
    logic signed [PE_W-1:0]     prod_e_c;
    logic [QUO_W-1:0]           one_minus_k;
    logic signed [PE_W:0]       rnd_e;
    logic signed [EST_X_W-1:0]  est_x;
    logic signed [SAMPLE_W-1:0] est_new;
    logic [PP_W-1:0]            rnd_p;
    logic [VAR_W+1:0]           var_sum;
    logic [VAR_W-1:0]           var_new;

    function automatic logic signed [DIFF_W-1:0] i_sample_hold_sx(
        input logic signed [SAMPLE_W-1:0] v
    );
        return {v[SAMPLE_W-1], v};
    endfunction

    // restoring divide: remainder shifts in P[0] on the first step, zeros after
    assign rem_sh = {r_rem, (r_cnt == '0) ? r_var[0] : 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    always_comb begin
        if (r_den_zero) begin
            k_c = '0;
        end else if (r_quo[QUO_W-1]) begin
            k_c = '1;
        end else begin
            k_c = r_quo[GAIN_W-1:0];
        end
    end

    assign diff_c      = {i_sample_hold_sx(r_sample)} - {r_est[SAMPLE_W-1], r_est};
    assign prod_e_c    = diff_c * $signed({1'b0, k_c});
    assign one_minus_k = {1'b1, {GAIN_W{1'b0}}} - {1'b0, r_k};

    assign rnd_e = {r_prod_e[PE_W-1], r_prod_e} + (PE_W+1)'(32768);
    assign est_x = {{(EST_X_W-SAMPLE_W){r_est[SAMPLE_W-1]}}, r_est}
                 + rnd_e[PE_W:GAIN_W];

    always_comb begin
        if (est_x > EST_X_W'(32767)) begin
            est_new = 16'sh7FFF;
        end else if (est_x < -(EST_X_W'(32768))) begin
            est_new = -16'sh8000;
        end else begin
            est_new = est_x[SAMPLE_W-1:0];
        end
    end

    assign rnd_p   = r_prod_p + PP_W'(32768);
    assign var_sum = {1'b0, rnd_p[PP_W-1:GAIN_W]} + {2'b00, r_q};
    assign var_new = (var_sum > {2'b00, {VAR_W{1'b1}}}) ? '1 : var_sum[VAR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q         <= RST_PROCESS_NOISE;
            r_r         <= RST_MEASURE_NOISE;
            r_p0        <= RST_START_VARIANCE;
            r_started   <= 1'b0;
            r_est       <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROCESS_NOISE:  r_q  <= i_cfg_data;
                    REG_MEASURE_NOISE:  r_r  <= i_cfg_data;
                    REG_START_VARIANCE: r_p0 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && !r_started) begin
                r_var     <= r_p0;
                r_started <= 1'b1;
            end
            if (i_cmd.update) begin
                r_est       <= est_new;
                r_var       <= var_new;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.div_init) begin
            r_den      <= {1'b0, r_var} + {1'b0, r_r};
            r_den_zero <= (r_var == '0) && (r_r == '0);
            r_rem      <= {2'b00, r_var[VAR_W-1:1]};
            r_quo      <= '0;
            r_cnt      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mul_e) begin
            r_k      <= k_c;
            r_prod_e <= prod_e_c;
        end
        if (i_cmd.mul_p) begin
            r_prod_p <= one_minus_k * r_var;
        end
        if (i_cmd.update) begin
            r_out <= est_new;
        end
    end

    assign o_status.div_done = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_estimate        = r_out;

endmodule

[rtl/skf_checker.sv]
module skf_sva (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic signed [skf_pkg::SAMPLE_W-1:0] i_sample,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [skf_pkg::SAMPLE_W-1:0] o_estimate,
    input logic                                i_cfg_we,
    input logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [skf_pkg::VAR_W-1:0]           i_cfg_data
);
    import skf_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a word is in flight");

    // the result never appears right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after accept");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_estimate)))
        else $error("stalled result dropped or changed");

endmodule

bind scalar_kalman_filter_top skf_sva u_skf_sva (.*);

[sim/skf_checker.sv]
module skf_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [skf_pkg::SAMPLE_W-1:0] i_estimate,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::VAR_W-1:0]           i_cfg_data,
    input  logic                                i_end,
    output int                                  o_pending,
    output int                                  o_fails
);
    import skf_pkg::*;

    localparam longint GAIN_MAX = 65535;
    localparam longint ONE_Q16  = 65536;
    localparam longint HALF_Q16 = 32768;
    localparam longint VAR_MAX  = 1048575;
    localparam longint EST_MAX  = 32767;
    localparam longint EST_MIN  = -32768;

    logic [VAR_W-1:0]           q_noise;
    logic [VAR_W-1:0]           r_noise;
    logic [VAR_W-1:0]           p_start;
    logic [VAR_W-1:0]           p_var;
    logic                       seen_first;
    logic signed [SAMPLE_W-1:0] est_state;
    logic signed [SAMPLE_W-1:0] estimate_q [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         errors;
    logic                       end_done;

    initial begin
        errors   = 0;
        end_done = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] exp_v,
                                   input logic signed [SAMPLE_W-1:0] got_v);
        $display("mismatch at %0t: %s (expected %0d, got %0d)", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    // advances the filter state by one sample, returns the new estimate
    function automatic logic signed [SAMPLE_W-1:0] next_estimate(
        input logic signed [SAMPLE_W-1:0] z
    );
        logic [VAR_W-1:0] p;
        logic [DEN_W-1:0] den;
        longint           quo;
        longint           gain;
        longint           diff;
        longint           delta;
        longint           est;
        longint           pn;
        p = seen_first ? p_var : p_start;
        den = DEN_W'(p) + DEN_W'(r_noise);
        if (den == '0) begin
            gain = 0;
        end else begin
            quo  = (longint'(p) << 16) / longint'(den);
            gain = (quo > GAIN_MAX) ? GAIN_MAX : quo;
        end
        diff  = longint'(z) - longint'(est_state);
        delta = (diff * gain + HALF_Q16) >>> 16;
        est   = longint'(est_state) + delta;
        if (est > EST_MAX) est = EST_MAX;
        if (est < EST_MIN) est = EST_MIN;
        pn = (((ONE_Q16 - gain) * longint'(p) + HALF_Q16) >>> 16) + longint'(q_noise);
        if (pn > VAR_MAX) pn = VAR_MAX;
        seen_first = 1'b1;
        p_var      = pn[VAR_W-1:0];
        est_state  = est[SAMPLE_W-1:0];
        return est_state;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            q_noise    = RST_PROCESS_NOISE;
            r_noise    = RST_MEASURE_NOISE;
            p_start    = RST_START_VARIANCE;
            p_var      = '0;
            seen_first = 1'b0;
            est_state  = '0;
            estimate_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (estimate_q.size() == 0) begin
                    report_mismatch("result word with nothing expected", '0, i_estimate);
                end else begin
                    want = estimate_q.pop_front();
                    if (i_estimate !== want) begin
                        report_mismatch("estimate", want, i_estimate);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PROCESS_NOISE:  q_noise = i_cfg_data;
                    REG_MEASURE_NOISE:  r_noise = i_cfg_data;
                    REG_START_VARIANCE: p_start = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                estimate_q.push_back(next_estimate(i_sample));
            end
            if (i_end && !end_done) begin
                end_done = 1'b1;
                if (estimate_q.size() != 0) begin
                    report_mismatch("expected words never came", estimate_q[0], '0);
                end
            end
        end
        o_pending <= estimate_q.size();
        o_fails   <= errors;
    end

endmodule

[sim/tb_scalar_kalman_filter_top.sv]
module tb_scalar_kalman_filter_top;
    import skf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [VAR_W-1:0]     VAR_TOP    = 20'hFFFFF;
    localparam int                   PHASES     = 8;
    localparam int                   PHASE_LEN  = 94;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idling;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] estimate;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [VAR_W-1:0]           cfg_data;
    logic                       end_flag;
    int                         pending;
    int                         fails;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    int                         level = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    scalar_kalman_filter_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_estimate  (estimate),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    skf_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_sample    (sample),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_estimate  (estimate),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_end       (end_flag),
        .o_pending   (pending),
        .o_fails     (fails)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endtask

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [VAR_W-1:0] q, input logic [VAR_W-1:0] r,
                                  input logic [VAR_W-1:0] p0);
        cfg_write(REG_PROCESS_NOISE, q);
        cfg_write(REG_MEASURE_NOISE, r);
        cfg_write(REG_START_VARIANCE, p0);
        cfg_write(REG_UNUSED, VAR_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VAR_W-1:0] pick_var();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return VAR_TOP;
        if (r < 5) return VAR_W'($urandom_range(1023));
        return VAR_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 4) return 16'sh7FFF;
        if (r < 8) return -16'sh8000;
        if (r < 10) return '0;
        if (r < 12) return -16'sd1;
        if (r < 45) begin
            v = level + $urandom_range(512) - 256;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[SAMPLE_W-1:0];
        end
        return SAMPLE_W'($urandom);
    endfunction

    initial begin
        logic signed [SAMPLE_W-1:0] dir0 [7];
        logic signed [SAMPLE_W-1:0] dir1 [8];
        logic signed [SAMPLE_W-1:0] dir2 [4];
        dir0 = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, -16'sh8000};
        dir1 = '{16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sd12345, -16'sd1,
                 16'sd0, 16'sd1};
        dir2 = '{-16'sh8000, 16'sh7FFF, -16'sd2, 16'sd2};

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        end_flag  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // R = 0 saturates the gain, then P decays to 0 with Q = 0: zero denominator
        set_idling(IDLE_NONE);
        apply_settings('0, '0, VAR_TOP);
        foreach (dir0[i]) send_word(dir0[i]);
        wait_drain();

        // start variance write after the first word must not matter
        set_idling(IDLE_SEND);
        apply_settings(VAR_TOP, VAR_TOP, '0);
        foreach (dir1[i]) send_word(dir1[i]);
        wait_drain();

        set_idling(IDLE_RECV);
        apply_settings(20'd1, 20'd1, VAR_TOP);
        foreach (dir2[i]) send_word(dir2[i]);
        wait_drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            set_idling(t_idling'(ph % 4));
            apply_settings(pick_var(), pick_var(), pick_var());
            level = $urandom_range(65535) - 32768;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n == PHASE_LEN / 2) wait_drain();
                if ($urandom_range(31) == 0) level = $urandom_range(65535) - 32768;
                send_word(pick_sample());
            end
            wait_drain();
        end

        repeat (40) @(posedge clk);
        end_flag <= 1'b1;
        repeat (3) @(posedge clk);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/skf_pkg.sv
rtl/skf_ctrl.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter_top.sv
rtl/skf_checker.sv
sim/skf_checker.sv
sim/tb_scalar_kalman_filter_top.sv
